// ----- src/plcb_pkg.sv -----
// Shared types and constants for the palette lookup and blend block.
package plcb_pkg;

   localparam int SLOT_W     = 4;
   localparam int PAL_DEPTH  = 1 << SLOT_W;
   localparam int CHAN_W     = 8;

   localparam logic       MODE_LOOKUP = 1'b0;
   localparam logic       MODE_WRITE  = 1'b1;
   localparam logic [7:0] BRIGHT_FULL = 8'hFF;
   localparam logic [7:0] BRIGHT_OFF  = 8'h00;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic              mode;
      logic [7:0]        index;
      logic [7:0]        brightness;
      logic              blend_on;
      logic [SLOT_W-1:0] slot;
      logic [CHAN_W-1:0] entry_red;
      logic [CHAN_W-1:0] entry_green;
      logic [CHAN_W-1:0] entry_blue;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
   } rsp_type;

endpackage

// ----- src/plcb_palette_ram.sv -----
// Palette memory: one write port, two registered read ports.
module plcb_palette_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [plcb_pkg::SLOT_W-1:0] wr_addr,
   input  plcb_pkg::color_type       wr_data,
   input  logic                      rd_en,
   input  logic [plcb_pkg::SLOT_W-1:0] rd_addr_a,
   input  logic [plcb_pkg::SLOT_W-1:0] rd_addr_b,
   output plcb_pkg::color_type       rd_data_a,
   output plcb_pkg::color_type       rd_data_b
);
   import plcb_pkg::*;

   color_type mem [PAL_DEPTH];
   color_type rd_a_ff;
   color_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- src/palette16_color_lookup_blend.sv -----
// Top level: 16-entry palette lookup with linear blend and brightness.
//
// Write items (mode 1) store one RGB color into a palette slot and give no
// result. Lookup items (mode 0) read the slot in index[7:4] and the following
// slot (15 wraps to 0) from a two-read-port palette memory in the same cycle,
// blend them by index[3:0] when blend_on is set, apply the brightness and
// return one color. The block takes one item per clock unless rsp_ready low
// stalls it. A lookup passes three register stages (memory read, blend
// multiply, brightness multiply) before its result is offered. The pipeline
// holds under rsp_ready low. A lookup must only name slots that were written
// since reset.
module palette16_color_lookup_blend (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  plcb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output plcb_pkg::rsp_type rsp_data
);
   import plcb_pkg::*;

   // c * m >> 8 with a 9-bit multiplier m
   function automatic logic [CHAN_W-1:0] scale_mul(input logic [CHAN_W-1:0] c,
                                                   input logic [8:0] m);
      logic [CHAN_W+8:0] p;
      p = c * m;
      return p[CHAN_W+7:8];
   endfunction

   logic rdy1, rdy2, rdy3;
   logic req_xfer;
   logic wr_en;

   // stage 1: memory read
   logic       v1_ff, v1_in;
   logic       blend1_ff;
   logic [7:0] f2_1_ff;
   logic [7:0] bright1_ff;
   color_type  col_a, col_b;
   logic [SLOT_W-1:0] slot_hi, slot_nxt;

   // stage 2: blended color
   logic       v2_ff, v2_in;
   color_type  col2_ff, col2_in;
   logic [7:0] bright2_ff;

   // stage 3: output register
   logic       v3_ff, v3_in;
   rsp_type    rsp_ff, rsp_in;

   assign rdy3 = !v3_ff || rsp_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_ready = rdy1;
   assign req_xfer  = req_valid && rdy1;
   assign wr_en     = req_xfer && (req_data.mode == MODE_WRITE);

   assign slot_hi  = req_data.index[7:4];
   assign slot_nxt = slot_hi + SLOT_W'(1);

   // One item per edge, so a lookup's read never meets a write in the same cycle.
   plcb_palette_ram u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (req_data.slot),
      .wr_data   ({req_data.entry_red, req_data.entry_green, req_data.entry_blue}),
      .rd_en     (rdy1),
      .rd_addr_a (slot_hi),
      .rd_addr_b (slot_nxt),
      .rd_data_a (col_a),
      .rd_data_b (col_b)
   );

   always_comb begin
      v1_in = v1_ff;
      if (rdy1) begin
         v1_in = req_xfer && (req_data.mode == MODE_LOOKUP);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         blend1_ff  <= req_data.blend_on && (req_data.index[3:0] != 4'd0);
         f2_1_ff    <= {req_data.index[3:0], 4'd0};
         bright1_ff <= req_data.brightness;
      end
   end

   // blend: c1 * (256 - f2) + c2 * (f2 + 1), each scaled down, sum wraps
   always_comb begin
      logic [8:0] w1;
      logic [8:0] w2;
      w1 = 9'd256 - {1'b0, f2_1_ff};
      w2 = {1'b0, f2_1_ff} + 9'd1;
      col2_in = col_a;
      if (blend1_ff) begin
         col2_in.red   = scale_mul(col_a.red,   w1) + scale_mul(col_b.red,   w2);
         col2_in.green = scale_mul(col_a.green, w1) + scale_mul(col_b.green, w2);
         col2_in.blue  = scale_mul(col_a.blue,  w1) + scale_mul(col_b.blue,  w2);
      end
   end

   always_comb begin
      v2_in = v2_ff;
      if (rdy2) begin
         v2_in = v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         col2_ff    <= col2_in;
         bright2_ff <= bright1_ff;
      end
   end

   // brightness: full passes, zero blanks, else scale by brightness + 2
   always_comb begin
      logic [8:0] m;
      m = {1'b0, bright2_ff} + 9'd2;
      rsp_in.out_red   = scale_mul(col2_ff.red,   m);
      rsp_in.out_green = scale_mul(col2_ff.green, m);
      rsp_in.out_blue  = scale_mul(col2_ff.blue,  m);
      if (bright2_ff == BRIGHT_FULL) begin
         rsp_in = {col2_ff.red, col2_ff.green, col2_ff.blue};
      end else if (bright2_ff == BRIGHT_OFF) begin
         rsp_in = '0;
      end
   end

   always_comb begin
      v3_in = v3_ff;
      if (rdy3) begin
         v3_in = v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- bench/tb_palette16_color_lookup_blend.sv -----
// Testbench for the 16-entry palette lookup and blend block: random and directed traffic.
`timescale 1ns / 100ps

module tb_palette16_color_lookup_blend;
   import plcb_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type   pending_items[$];
   rsp_type   expected_colors[$];
   color_type palette_copy[PAL_DEPTH];

   int   send_idle_pct = 36;
   int   recv_idle_pct = 73;
   int   phase_num     = 1;
   int   error_count   = 0;
   logic hold_off      = 1'b0;

   palette16_color_lookup_blend uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] scale8(input logic [7:0] v, input logic [7:0] s);
      int prod;
      prod = int'(v) * (int'(s) + 1);
      return prod[15:8];
   endfunction

   // Update the palette copy on writes; queue the expected color on lookups.
   task automatic palette_apply(input req_type item);
      color_type  cur;
      color_type  nxt;
      logic [7:0] chan[3];
      logic [7:0] nchan[3];
      logic [7:0] f1;
      logic [7:0] f2;
      logic [3:0] hi;
      logic [3:0] frac;
      if (item.mode == MODE_WRITE) begin
         palette_copy[item.slot] = {item.entry_red, item.entry_green, item.entry_blue};
      end else begin
         hi    = item.index[7:4];
         frac  = item.index[3:0];
         cur   = palette_copy[hi];
         nxt   = palette_copy[hi + 4'd1];
         chan  = '{cur.red, cur.green, cur.blue};
         nchan = '{nxt.red, nxt.green, nxt.blue};
         if (item.blend_on && frac != 4'd0) begin
            f2 = {frac, 4'h0};
            f1 = 8'd255 - f2;
            for (int c = 0; c < 3; c++) begin
               chan[c] = scale8(chan[c], f1) + scale8(nchan[c], f2);
            end
         end
         if (item.brightness == BRIGHT_OFF) begin
            chan = '{8'd0, 8'd0, 8'd0};
         end else if (item.brightness != BRIGHT_FULL) begin
            for (int c = 0; c < 3; c++) begin
               chan[c] = scale8(chan[c], item.brightness + 8'd1);
            end
         end
         expected_colors.push_back({chan[0], chan[1], chan[2]});
      end
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   function automatic req_type make_write(input logic [3:0] slot, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b);
      req_type item;
      item             = req_type'({$urandom, $urandom});
      item.mode        = MODE_WRITE;
      item.slot        = slot;
      item.entry_red   = r;
      item.entry_green = g;
      item.entry_blue  = b;
      return item;
   endfunction

   function automatic req_type make_lookup(input logic [7:0] index, input logic [7:0] bright,
                                           input logic blend);
      req_type item;
      item            = req_type'({$urandom, $urandom});
      item.mode       = MODE_LOOKUP;
      item.index      = index;
      item.brightness = bright;
      item.blend_on   = blend;
      return item;
   endfunction

   task automatic fill_random(input int count);
      logic [7:0] bright;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            pending_items.push_back(make_write(4'($urandom_range(15)),
                                               8'($urandom_range(255)),
                                               8'($urandom_range(255)),
                                               8'($urandom_range(255))));
         end else begin
            bright = 8'($urandom_range(255));
            // favor the brightness edges now and then
            if ($urandom_range(7) == 0) begin
               case ($urandom_range(3))
                  0: bright = BRIGHT_OFF;
                  1: bright = BRIGHT_FULL;
                  2: bright = 8'd1;
                  default: bright = 8'd254;
               endcase
            end
            pending_items.push_back(make_lookup(8'($urandom_range(255)), bright,
                                                1'($urandom_range(1))));
         end
      end
   endtask

   // Driver: advance to the next item once the current one transfers.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            palette_apply(req_data);
         end
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: compare every result transfer against the oldest expected color.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_colors.size() == 0) begin
            report_mismatch("unexpected result", 0, int'(rsp_data));
         end else begin
            want = expected_colors.pop_front();
            if (rsp_data.out_red !== want.out_red)
               report_mismatch("red", int'(want.out_red), int'(rsp_data.out_red));
            if (rsp_data.out_green !== want.out_green)
               report_mismatch("green", int'(want.out_green), int'(rsp_data.out_green));
            if (rsp_data.out_blue !== want.out_blue)
               report_mismatch("blue", int'(want.out_blue), int'(rsp_data.out_blue));
         end
      end
   end

   // Stall the result side for a long stretch early in the last phase.
   initial begin
      while (phase_num != 3) @(posedge clock);
      repeat (20) @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("palette16_color_lookup_blend verification failed");
      $finish;
   end

   initial begin
      foreach (palette_copy[i]) palette_copy[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // load every slot first so no lookup touches an unwritten entry
      pending_items.push_back(make_write(4'd0, 8'h00, 8'h00, 8'h00));
      pending_items.push_back(make_write(4'd1, 8'hFF, 8'hFF, 8'hFF));
      pending_items.push_back(make_write(4'd2, 8'hFF, 8'h00, 8'hAA));
      pending_items.push_back(make_write(4'd3, 8'h00, 8'hFF, 8'h55));
      for (int s = 4; s < 15; s++) begin
         pending_items.push_back(make_write(4'(s), 8'($urandom_range(255)),
                                            8'($urandom_range(255)),
                                            8'($urandom_range(255))));
      end
      pending_items.push_back(make_write(4'd15, 8'hFF, 8'h80, 8'h01));

      pending_items.push_back(make_lookup(8'h00, BRIGHT_FULL, 1'b0));
      pending_items.push_back(make_lookup(8'h1F, BRIGHT_FULL, 1'b1));
      pending_items.push_back(make_lookup(8'hF8, 8'd128, 1'b1));
      pending_items.push_back(make_lookup(8'hFF, BRIGHT_FULL, 1'b1));
      pending_items.push_back(make_lookup(8'h10, BRIGHT_FULL, 1'b1));
      pending_items.push_back(make_lookup(8'h37, 8'd200, 1'b0));
      pending_items.push_back(make_lookup(8'h1A, BRIGHT_OFF, 1'b1));
      pending_items.push_back(make_lookup(8'h21, 8'd1, 1'b1));
      pending_items.push_back(make_lookup(8'h18, 8'd254, 1'b1));

      fill_random(470);
      while (pending_items.size() != 0) @(posedge clock);

      send_idle_pct = 73;
      recv_idle_pct = 36;
      phase_num     = 2;
      fill_random(465);
      while (pending_items.size() != 0) @(posedge clock);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      phase_num     = 3;
      fill_random(465);

      while (pending_items.size() != 0 || req_valid || expected_colors.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("palette16_color_lookup_blend verification clean");
      end else begin
         $display("palette16_color_lookup_blend verification failed");
      end
      $finish;
   end

endmodule
